// ===== design/tbpf_pkg.sv =====
// shared types and constants for the tiled background pixel fetch unit
// memory sizes, command, register and map size codes, memory control structs
// no dependencies
package tbpf_pkg;

    localparam int VIDEO_WORDS   = 32768;
    localparam int PALETTE_WORDS = 256;
    localparam int VRAM_AW       = $clog2(VIDEO_WORDS);
    localparam int PAL_AW        = $clog2(PALETTE_WORDS);

    typedef enum logic [1:0] {
        CMD_VRAM_WRITE = 2'd0,
        CMD_PAL_WRITE  = 2'd1,
        CMD_PIXEL      = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        REG_SCROLL_X    = 3'd0,
        REG_SCROLL_Y    = 3'd1,
        REG_MAP_BASE    = 3'd2,
        REG_CHAR_BASE   = 3'd3,
        REG_MAP_SIZE    = 3'd4,
        REG_WIDE_COLOUR = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MAP_32X32 = 2'd0,
        MAP_64X32 = 2'd1,
        MAP_32X64 = 2'd2,
        MAP_64X64 = 2'd3
    } map_size_t;

    typedef logic [VRAM_AW-1:0] vram_addr_t;
    typedef logic [PAL_AW-1:0]  pal_addr_t;

    typedef struct packed {
        logic        wr_en;
        vram_addr_t  wr_addr;
        logic [15:0] wr_data;
        logic        rd_en;
        vram_addr_t  map_addr;
        vram_addr_t  char_addr;
    } vram_ctrl_t;

    typedef struct packed {
        logic        wr_en;
        pal_addr_t   wr_addr;
        logic [15:0] wr_data;
        logic        rd_en;
        pal_addr_t   rd_addr;
    } pal_ctrl_t;

endpackage

// ===== design/tbpf_if.sv =====
// channel interfaces of the tiled background pixel fetch unit
// request, result and configuration write channels; no dependencies
interface tbpf_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [14:0] mem_address;
    logic [15:0] write_data;
    logic [7:0]  pixel_column;
    logic [7:0]  scan_line;

    modport source (
        output valid, command, mem_address, write_data, pixel_column, scan_line,
        input  ready
    );
    modport sink (
        input  valid, command, mem_address, write_data, pixel_column, scan_line,
        output ready
    );
endinterface

interface tbpf_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] colour;
    logic        transparent;

    modport source (
        output valid, colour, transparent,
        input  ready
    );
    modport sink (
        input  valid, colour, transparent,
        output ready
    );
endinterface

interface tbpf_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [8:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== design/tbpf_vram.sv =====
// video ram: one write port and two registered read ports (map entry, char data)
// depends on tbpf_pkg
module tbpf_vram
    import tbpf_pkg::*;
(
    input  logic        clk,
    input  vram_ctrl_t  ctrl,
    output logic [15:0] map_rdata,
    output logic [15:0] char_rdata
);

    logic [15:0] vram_mem [VIDEO_WORDS];
    logic [15:0] map_rdata_reg;
    logic [15:0] char_rdata_reg;

    // read-before-write on the same edge
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            vram_mem[ctrl.wr_addr] <= ctrl.wr_data;
        end
        if (ctrl.rd_en)
        begin
            map_rdata_reg  <= vram_mem[ctrl.map_addr];
            char_rdata_reg <= vram_mem[ctrl.char_addr];
        end
    end

    assign map_rdata  = map_rdata_reg;
    assign char_rdata = char_rdata_reg;

endmodule

// ===== design/tbpf_palette.sv =====
// palette ram: one write port and one registered read port
// depends on tbpf_pkg
module tbpf_palette
    import tbpf_pkg::*;
(
    input  logic        clk,
    input  pal_ctrl_t   ctrl,
    output logic [15:0] rdata
);

    logic [15:0] pal_mem [PALETTE_WORDS];
    logic [15:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            pal_mem[ctrl.wr_addr] <= ctrl.wr_data;
        end
        if (ctrl.rd_en)
        begin
            rdata_reg <= pal_mem[ctrl.rd_addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/tiled_background_pixel_fetch_unit.sv =====
// top level of the tiled background pixel fetch unit
// depends on tbpf_pkg, tbpf_if, tbpf_vram, tbpf_palette
//
// The unit takes one request per clock unless the pipeline holds: video ram
// writes, palette writes and pixel requests share the request channel and are
// handled strictly in order. A pixel request runs through four pipeline stages
// (map entry read, character data read, palette read, result register); writes
// produce no result. The video ram has one write port and two read ports, so the
// map and character reads of different pixels overlap; a video write is done at
// acceptance and a palette write at the palette read stage, which keeps every
// read consistent with request order. While the result register holds an
// untaken result the whole pipeline holds. Configuration registers are written
// through the cfg channel, always ready.
module tiled_background_pixel_fetch_unit
    import tbpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tbpf_cfg_if.sink    cfg,
    tbpf_req_if.sink    req,
    tbpf_rsp_if.source  rsp
);

    typedef struct packed {
        logic        pixel;
        logic        pal_wr;
        logic [7:0]  pal_waddr;
        logic [15:0] data;
        logic [2:0]  cx;
        logic [2:0]  cy;
    } s1_t;

    typedef struct packed {
        logic        pixel;
        logic        pal_wr;
        logic [7:0]  pal_waddr;
        logic [15:0] data;
        logic        byte_hi;
        logic        nib_hi;
        logic [3:0]  bank;
    } s2_t;

    // configuration registers
    logic [8:0]  scroll_x_reg;
    logic [8:0]  scroll_y_reg;
    logic [4:0]  map_base_reg;
    logic [1:0]  char_base_reg;
    logic [1:0]  map_size_reg;
    logic        wide_reg;

    // pipeline
    logic        adv;
    logic        acc;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    s1_t         s1_reg;
    s1_t         s1_next;
    logic        s2_valid_reg;
    s2_t         s2_reg;
    s2_t         s2_next;
    logic        s3_valid_reg;
    logic        s3_transp_reg;
    logic        s3_transp_next;
    logic        out_valid_reg;
    logic [15:0] out_colour_reg;
    logic        out_transp_reg;

    // address paths
    logic [8:0]  sx;
    logic [8:0]  sy;
    logic [11:0] map_idx;
    logic [15:0] map_half;
    logic [15:0] map_entry;
    logic [15:0] char_word;
    logic [2:0]  cx_f;
    logic [2:0]  cy_f;
    logic [16:0] char_byte;
    logic [7:0]  char_b;
    logic [3:0]  nib;
    logic [7:0]  cidx;
    logic [7:0]  pal_idx;
    logic [15:0] pal_rdata;

    vram_ctrl_t  vram_ctrl;
    pal_ctrl_t   pal_ctrl;

    // configuration port
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scroll_x_reg  <= '0;
            scroll_y_reg  <= '0;
            map_base_reg  <= '0;
            char_base_reg <= '0;
            map_size_reg  <= '0;
            wide_reg      <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_SCROLL_X:    scroll_x_reg  <= cfg.data;
                REG_SCROLL_Y:    scroll_y_reg  <= cfg.data;
                REG_MAP_BASE:    map_base_reg  <= cfg.data[4:0];
                REG_CHAR_BASE:   char_base_reg <= cfg.data[1:0];
                REG_MAP_SIZE:    map_size_reg  <= cfg.data[1:0];
                REG_WIDE_COLOUR: wide_reg      <= cfg.data[0];
                default:         ;
            endcase
        end
    end

    // handshake
    assign adv       = !out_valid_reg || rsp.ready;
    assign req.ready = adv;
    assign acc       = req.valid && adv;

    // stage 0: scrolled position and map entry address
    always_comb
    begin
        sx = 9'({1'b0, req.pixel_column} + scroll_x_reg);
        sy = 9'({1'b0, req.scan_line} + scroll_y_reg);
        map_idx = {2'b00, sy[7:3], sx[7:3]};
        unique case (map_size_reg)
            MAP_64X32: map_idx[10] = sx[8];
            MAP_32X64: map_idx[10] = sy[8];
            MAP_64X64:
            begin
                map_idx[10] = sx[8];
                map_idx[11] = sy[8];
            end
            default: ;
        endcase
        map_half = {1'b0, map_base_reg, 10'b0} + {4'b0, map_idx};

        s1_valid_next = acc && ((req.command == CMD_PIXEL) || (req.command == CMD_PAL_WRITE));
        s1_next.pixel     = req.command == CMD_PIXEL;
        s1_next.pal_wr    = req.command == CMD_PAL_WRITE;
        s1_next.pal_waddr = req.mem_address[7:0];
        s1_next.data      = req.write_data;
        s1_next.cx        = sx[2:0];
        s1_next.cy        = sy[2:0];
    end

    // stage 1: flips and character data address
    always_comb
    begin
        cx_f = s1_reg.cx ^ {3{map_entry[10]}};
        cy_f = s1_reg.cy ^ {3{map_entry[11]}};
        if (wide_reg)
        begin
            char_byte = 17'({char_base_reg, 14'b0}) + 17'({map_entry[9:0], 6'b0})
                      + 17'({cy_f, cx_f});
        end
        else
        begin
            char_byte = 17'({char_base_reg, 14'b0}) + 17'({map_entry[9:0], 5'b0})
                      + 17'({cy_f, cx_f[2:1]});
        end

        s2_next.pixel     = s1_reg.pixel;
        s2_next.pal_wr    = s1_reg.pal_wr;
        s2_next.pal_waddr = s1_reg.pal_waddr;
        s2_next.data      = s1_reg.data;
        s2_next.byte_hi   = char_byte[0];
        s2_next.nib_hi    = cx_f[0];
        s2_next.bank      = map_entry[15:12];
    end

    // stage 2: colour index and palette address
    always_comb
    begin
        char_b = s2_reg.byte_hi ? char_word[15:8] : char_word[7:0];
        nib    = s2_reg.nib_hi ? char_b[7:4] : char_b[3:0];
        if (wide_reg)
        begin
            cidx    = char_b;
            pal_idx = char_b;
        end
        else
        begin
            cidx    = {4'b0, nib};
            pal_idx = {s2_reg.bank, nib};
        end
        s3_transp_next = cidx == 8'd0;
    end

    // memory control
    always_comb
    begin
        vram_ctrl.wr_en     = acc && (req.command == CMD_VRAM_WRITE);
        vram_ctrl.wr_addr   = VRAM_AW'(req.mem_address);
        vram_ctrl.wr_data   = req.write_data;
        vram_ctrl.rd_en     = adv;
        vram_ctrl.map_addr  = VRAM_AW'(map_half);
        vram_ctrl.char_addr = VRAM_AW'(char_byte[16:1]);

        pal_ctrl.wr_en   = adv && s2_valid_reg && s2_reg.pal_wr;
        pal_ctrl.wr_addr = PAL_AW'(s2_reg.pal_waddr);
        pal_ctrl.wr_data = s2_reg.data;
        pal_ctrl.rd_en   = adv;
        pal_ctrl.rd_addr = PAL_AW'(pal_idx);
    end

    tbpf_vram u_vram (
        .clk        (clk),
        .ctrl       (vram_ctrl),
        .map_rdata  (map_entry),
        .char_rdata (char_word)
    );

    tbpf_palette u_palette (
        .clk   (clk),
        .ctrl  (pal_ctrl),
        .rdata (pal_rdata)
    );

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg && s2_reg.pixel;
            out_valid_reg <= s3_valid_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg         <= s1_next;
            s2_reg         <= s2_next;
            s3_transp_reg  <= s3_transp_next;
            out_colour_reg <= s3_transp_reg ? 16'h0000 : pal_rdata;
            out_transp_reg <= s3_transp_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.colour      = out_colour_reg;
    assign rsp.transparent = out_transp_reg;

endmodule

// ===== verif/tiled_background_pixel_fetch_unit_tb.sv =====
// self-checking testbench for the tiled background pixel fetch unit
// predicts every pixel from shadow copies of video ram, palette ram and registers
// depends on tbpf_pkg, tbpf_if and tiled_background_pixel_fetch_unit
module tiled_background_pixel_fetch_unit_tb;
    import tbpf_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int SETTLE_CYCLES  = 8;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [2:0] CFG_SPARE_A = 3'd6;
    localparam logic [2:0] CFG_SPARE_B = 3'd7;

    localparam int STALL_NONE   = 0;
    localparam int STALL_COIN   = 1;
    localparam int STALL_SPARSE = 2;
    localparam int STALL_RUNS   = 3;

    typedef struct packed {
        logic [15:0] colour;
        logic        transparent;
    } pixel_result_t;

    logic clk;
    logic rst_n;

    tbpf_cfg_if cfg_ch ();
    tbpf_req_if req_ch ();
    tbpf_rsp_if rsp_ch ();

    tiled_background_pixel_fetch_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow state of the block
    logic [15:0] video_shadow    [VIDEO_WORDS];
    bit          video_written   [VIDEO_WORDS];
    logic [15:0] palette_shadow  [PALETTE_WORDS];
    bit          palette_written [PALETTE_WORDS];

    logic [8:0] view_scroll_x = '0;
    logic [8:0] view_scroll_y = '0;
    logic [4:0] map_block     = '0;
    logic [1:0] char_block    = '0;
    logic [1:0] map_layout    = MAP_32X32;
    logic       wide_colour   = 1'b0;

    pixel_result_t pending_pixels[$];
    int failures      = 0;
    int requests_sent = 0;
    int burst_left    = 0;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("== FAIL ==");
        $finish;
    end

    function automatic int map_word_of(logic [7:0] px, logic [7:0] py);
        logic [8:0] sx;
        logic [8:0] sy;
        int         idx;
        sx  = 9'(px) + view_scroll_x;
        sy  = 9'(py) + view_scroll_y;
        idx = int'(sy[7:3]) * 32 + int'(sx[7:3]);
        case (map_layout)
            MAP_64X32: idx += int'(sx[8]) * 1024;
            MAP_32X64: idx += int'(sy[8]) * 1024;
            MAP_64X64: idx += int'(sx[8]) * 1024 + int'(sy[8]) * 2048;
            default: ;
        endcase
        return (int'(map_block) * 1024 + idx) % VIDEO_WORDS;
    endfunction

    function automatic logic [2:0] tile_col(logic [15:0] entry, logic [7:0] px);
        logic [8:0] sx;
        sx = 9'(px) + view_scroll_x;
        return entry[10] ? ~sx[2:0] : sx[2:0];
    endfunction

    function automatic logic [2:0] tile_row(logic [15:0] entry, logic [7:0] py);
        logic [8:0] sy;
        sy = 9'(py) + view_scroll_y;
        return entry[11] ? ~sy[2:0] : sy[2:0];
    endfunction

    function automatic int char_byte_addr(logic [15:0] entry, logic [7:0] px, logic [7:0] py);
        logic [2:0] cx;
        logic [2:0] cy;
        int         addr;
        cx = tile_col(entry, px);
        cy = tile_row(entry, py);
        if (wide_colour)
            addr = int'(char_block) * 16384 + int'(entry[9:0]) * 64 + int'(cy) * 8 + int'(cx);
        else
            addr = int'(char_block) * 16384 + int'(entry[9:0]) * 32 + int'(cy) * 4
                 + int'(cx[2:1]);
        return addr % (2 * VIDEO_WORDS);
    endfunction

    function automatic logic [7:0] colour_index(logic [15:0] entry, logic [7:0] px,
                                                logic [7:0] py);
        logic [2:0]  cx;
        int          addr;
        logic [15:0] half;
        logic [7:0]  octet;
        cx    = tile_col(entry, px);
        addr  = char_byte_addr(entry, px, py);
        half  = video_shadow[addr >> 1];
        octet = addr[0] ? half[15:8] : half[7:0];
        if (wide_colour)
            return octet;
        return {4'h0, cx[0] ? octet[7:4] : octet[3:0]};
    endfunction

    function automatic int palette_slot(logic [15:0] entry, logic [7:0] cidx);
        if (wide_colour)
            return int'(cidx) % PALETTE_WORDS;
        return (int'(entry[15:12]) * 16 + int'(cidx)) % PALETTE_WORDS;
    endfunction

    function automatic void predict_pixel(logic [7:0] px, logic [7:0] py);
        logic [15:0]   entry;
        logic [7:0]    cidx;
        pixel_result_t want;
        entry            = video_shadow[map_word_of(px, py)];
        cidx             = colour_index(entry, px, py);
        want.transparent = (cidx == 8'd0);
        want.colour      = want.transparent ? 16'h0000
                                            : palette_shadow[palette_slot(entry, cidx)];
        pending_pixels.push_back(want);
    endfunction

    function automatic void apply_register(logic [2:0] idx, logic [8:0] value);
        case (idx)
            REG_SCROLL_X:    view_scroll_x = value;
            REG_SCROLL_Y:    view_scroll_y = value;
            REG_MAP_BASE:    map_block     = value[4:0];
            REG_CHAR_BASE:   char_block    = value[1:0];
            REG_MAP_SIZE:    map_layout    = value[1:0];
            REG_WIDE_COLOUR: wide_colour   = value[0];
            default: ;
        endcase
    endfunction

    function automatic logic [15:0] random_char_half();
        return ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
    endfunction

    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(1, 24);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic issue_request(logic [1:0] command, logic [14:0] addr, logic [15:0] data,
                                 logic [7:0] px, logic [7:0] py);
        req_ch.valid        <= 1'b1;
        req_ch.command      <= command;
        req_ch.mem_address  <= addr;
        req_ch.write_data   <= data;
        req_ch.pixel_column <= px;
        req_ch.scan_line    <= py;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        case (command)
            CMD_VRAM_WRITE:
            begin
                video_shadow[int'(addr) % VIDEO_WORDS]  = data;
                video_written[int'(addr) % VIDEO_WORDS] = 1'b1;
            end
            CMD_PAL_WRITE:
            begin
                palette_shadow[int'(addr[7:0]) % PALETTE_WORDS]  = data;
                palette_written[int'(addr[7:0]) % PALETTE_WORDS] = 1'b1;
            end
            CMD_PIXEL: predict_pixel(px, py);
            default: ;
        endcase
        if (command != CMD_UNUSED)
            requests_sent++;
        pace_sender();
    endtask

    // writes whatever the pixel would read that is still unwritten, then requests it
    task automatic fetch_pixel(logic [7:0] px, logic [7:0] py);
        int          mw;
        int          cw;
        int          slot;
        logic [15:0] entry;
        logic [7:0]  cidx;
        mw = map_word_of(px, py);
        if (!video_written[mw])
            issue_request(CMD_VRAM_WRITE, 15'(mw), 16'($urandom), 8'($urandom), 8'($urandom));
        entry = video_shadow[mw];
        cw    = char_byte_addr(entry, px, py) >> 1;
        if (!video_written[cw])
            issue_request(CMD_VRAM_WRITE, 15'(cw), random_char_half(), 8'($urandom),
                          8'($urandom));
        cidx = colour_index(entry, px, py);
        slot = palette_slot(entry, cidx);
        if (!palette_written[slot])
            issue_request(CMD_PAL_WRITE, {7'($urandom), 8'(slot)}, 16'($urandom),
                          8'($urandom), 8'($urandom));
        issue_request(CMD_PIXEL, 15'($urandom), 16'($urandom), px, py);
    endtask

    task automatic place_map_entry(logic [7:0] px, logic [7:0] py, logic [15:0] entry);
        issue_request(CMD_VRAM_WRITE, 15'(map_word_of(px, py)), entry, 8'($urandom),
                      8'($urandom));
    endtask

    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_registers(logic [8:0] sx, logic [8:0] sy, logic [8:0] mb,
                                     logic [8:0] cb, logic [8:0] ms, logic [8:0] wc,
                                     bit add_spare);
        logic [2:0] idx_list[$];
        logic [8:0] val_list[$];
        idx_list = '{REG_SCROLL_X, REG_SCROLL_Y, REG_MAP_BASE, REG_CHAR_BASE, REG_MAP_SIZE,
                     REG_WIDE_COLOUR};
        val_list = '{sx, sy, mb, cb, ms, wc};
        if (add_spare)
        begin
            idx_list.push_front(CFG_SPARE_A);
            val_list.push_front(9'($urandom));
            idx_list.push_back(CFG_SPARE_B);
            val_list.push_back(9'($urandom));
        end
        foreach (idx_list[i])
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx_list[i];
            cfg_ch.data  <= val_list[i];
            do @(posedge clk); while (cfg_ch.ready !== 1'b1);
            apply_register(idx_list[i], val_list[i]);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_traffic(int count);
        int          stop_at;
        int          pick;
        int          mw;
        logic [7:0]  px;
        logic [7:0]  py;
        logic [15:0] entry;
        stop_at = requests_sent + count;
        while (requests_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            px   = 8'($urandom);
            py   = 8'($urandom);
            if (pick < 60)
                fetch_pixel(px, py);
            else if (pick < 70)
            begin
                // rewrite the map entry right before reading it back
                place_map_entry(px, py, 16'($urandom));
                fetch_pixel(px, py);
            end
            else if (pick < 77)
            begin
                mw = map_word_of(px, py);
                if (video_written[mw])
                begin
                    entry = video_shadow[mw];
                    issue_request(CMD_VRAM_WRITE, 15'(char_byte_addr(entry, px, py) >> 1),
                                  random_char_half(), 8'($urandom), 8'($urandom));
                end
                fetch_pixel(px, py);
            end
            else if (pick < 85)
                issue_request(CMD_VRAM_WRITE, 15'($urandom), 16'($urandom), px, py);
            else if (pick < 93)
                issue_request(CMD_PAL_WRITE, 15'($urandom), 16'($urandom), px, py);
            else
                issue_request(CMD_UNUSED, 15'($urandom), 16'($urandom), px, py);
        end
    endtask

    task automatic test_directed_cases();
        program_registers(9'd0, 9'd0, 9'd0, 9'd0, 9'(MAP_32X32), 9'd0, 1'b0);
        issue_request(CMD_VRAM_WRITE, 15'h0000, 16'hFFFF, 8'h00, 8'h00);
        issue_request(CMD_VRAM_WRITE, 15'h7FFF, 16'h0000, 8'hFF, 8'hFF);
        issue_request(CMD_PAL_WRITE, 15'h7FFF, 16'hFFFF, 8'hFF, 8'h00);
        issue_request(CMD_PAL_WRITE, 15'h0000, 16'h0000, 8'h00, 8'hFF);
        issue_request(CMD_UNUSED, 15'h5555, 16'hAAAA, 8'hAA, 8'h55);
        // flipped tile 1023 with the top palette bank, then the far screen corner
        fetch_pixel(8'd0, 8'd0);
        fetch_pixel(8'd255, 8'd255);
        // zero character data gives transparent pixels, then nibble order within a byte
        place_map_entry(8'd16, 8'd8, 16'h0005);
        issue_request(CMD_VRAM_WRITE, 15'd80, 16'h0000, 8'h00, 8'h00);
        issue_request(CMD_VRAM_WRITE, 15'd81, 16'h21A0, 8'h00, 8'h00);
        fetch_pixel(8'd16, 8'd8);
        fetch_pixel(8'd20, 8'd8);
        fetch_pixel(8'd21, 8'd8);
        place_map_entry(8'd24, 8'd8, 16'h3C05);
        fetch_pixel(8'd24, 8'd8);
        // scroll wrap across the 512 pixel map in 256 colour mode
        wait_for_results();
        program_registers(9'h1F8, 9'h1F8, 9'd0, 9'd1, 9'(MAP_64X64), 9'd1, 1'b0);
        fetch_pixel(8'd0, 8'd0);
        fetch_pixel(8'd8, 8'd8);
    endtask

    task automatic test_register_extremes();
        wait_for_results();
        program_registers(9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF, 1'b0);
        random_traffic(200);
        wait_for_results();
        program_registers(9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 1'b0);
        random_traffic(150);
    endtask

    task automatic test_map_layouts();
        logic [1:0] layouts[4] = '{MAP_32X32, MAP_64X32, MAP_32X64, MAP_64X64};
        foreach (layouts[i])
        begin
            for (int wide = 0; wide < 2; wide++)
            begin
                wait_for_results();
                program_registers(9'($urandom), 9'($urandom), 9'($urandom), 9'($urandom),
                                  {7'($urandom), layouts[i]}, {8'($urandom), 1'(wide)},
                                  1'b0);
                random_traffic(90);
            end
        end
    endtask

    task automatic test_random_settings();
        repeat (6)
        begin
            wait_for_results();
            program_registers(9'($urandom), 9'($urandom), 9'($urandom), 9'($urandom),
                              9'($urandom), 9'($urandom), 1'b1);
            random_traffic(90);
        end
    endtask

    // result side stalls, switching its pattern at random
    initial
    begin
        int stall_mode;
        int mode_left;
        int run_left;
        bit hold;
        rsp_ch.ready = 1'b0;
        stall_mode   = STALL_NONE;
        mode_left    = 0;
        run_left     = 0;
        hold         = 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(STALL_NONE, STALL_RUNS);
                mode_left  = $urandom_range(16, 96);
            end
            mode_left--;
            case (stall_mode)
                STALL_NONE:   rsp_ch.ready <= 1'b1;
                STALL_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
                STALL_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                default:
                begin
                    if (run_left == 0)
                    begin
                        hold     = ~hold;
                        run_left = hold ? $urandom_range(1, 4) : $urandom_range(1, 12);
                    end
                    run_left--;
                    rsp_ch.ready <= hold;
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        pixel_result_t want;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("result with no pixel request pending: colour %h transparent %b",
                       rsp_ch.colour, rsp_ch.transparent);
                failures++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (rsp_ch.colour !== want.colour)
                begin
                    $error("colour: expected %h, actual %h", want.colour, rsp_ch.colour);
                    failures++;
                end
                if (rsp_ch.transparent !== want.transparent)
                begin
                    $error("transparent: expected %b, actual %b", want.transparent,
                           rsp_ch.transparent);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.command      = CMD_VRAM_WRITE;
        req_ch.mem_address  = '0;
        req_ch.write_data   = '0;
        req_ch.pixel_column = '0;
        req_ch.scan_line    = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = REG_SCROLL_X;
        cfg_ch.data         = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_register_extremes();
        test_map_layouts();
        test_random_settings();
        wait_for_results();

        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
